>>> hdl/hast_pkg.sv
// shared types and constants for the hierarchical allocation stats tracker
// no dependencies
package hast_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned IdW     = 16;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned CntW    = 32;
  localparam int unsigned BytesW  = 48;
  localparam int unsigned StatusW = 3;

  // one stats word in the stats memory, alloc count in the low bits
  localparam int unsigned StatsW  = 2 * CntW + 2 * BytesW;
  // one id word: domain id low, parent id high
  localparam int unsigned IdWordW = 2 * IdW;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 168;

  localparam logic [ModeW-1:0] ModeClear = 3'd0;
  localparam logic [ModeW-1:0] ModeReg   = 3'd1;
  localparam logic [ModeW-1:0] ModeAlloc = 3'd2;
  localparam logic [ModeW-1:0] ModeFree  = 3'd3;

  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StFull      = 3'd1;
  localparam logic [StatusW-1:0] StDup       = 3'd2;
  localparam logic [StatusW-1:0] StNoParent  = 3'd3;
  localparam logic [StatusW-1:0] StUnknown   = 3'd4;
  localparam logic [StatusW-1:0] StUnderflow = 3'd5;

  typedef enum logic [2:0] {
    LkDup,
    LkPar,
    LkChk,
    LkWalk,
    LkFin
  } lookup_e;

endpackage

>>> hdl/hierarchical_alloc_stats_tracker.sv
// top level of the hierarchical allocation stats tracker
// depends on hast_pkg and hast_ram
//
// usage:
//  - s_axis carries one request per transfer: mode, domain id, parent id, size
//  - m_axis carries one result per request: status and the named domain's stats
//  - cfg_we_i / cfg_wdata_i write invalid_id (the "no parent" id); write only when idle
//  - one request is worked on at a time; s_axis_tready is high only while idle
//  - domain ids live in an id memory that is searched linearly, one entry at a
//    time, each entry with a read state and then a compare state
//  - alloc/free walk the parent chain: per level one lookup plus a
//    read-modify-write of the stats memory; a parent id missing from the table
//    ends the walk
//  - the next request can be taken in the same cycle that the result becomes valid
//  - reset empties the table (count to zero) and sets invalid_id to zero; memories
//    are not cleared, entries past the count are never read
//  - a stalled m_axis holds the result; a following request can still be taken,
//    but its result waits in S_OUT until the result register has room again
module hierarchical_alloc_stats_tracker #(
  parameter int unsigned MAX_DOMAINS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                               cfg_we_i,
  input  logic [hast_pkg::IdW-1:0]           cfg_wdata_i,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // mode[2:0], domain_id[18:3], parent_id[34:19], size_bytes[66:35], zeros above
  input  logic [hast_pkg::InDataW-1:0]       s_axis_tdata,

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[2:0], alloc_total[34:3], free_total[66:35], live_bytes[114:67],
  // peak_live_bytes[162:115], zeros above
  output logic [hast_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned AW = $clog2(MAX_DOMAINS);
  localparam int unsigned CW = $clog2(MAX_DOMAINS + 1);
  localparam int unsigned IdW = hast_pkg::IdW;
  localparam int unsigned CntW = hast_pkg::CntW;
  localparam int unsigned BytesW = hast_pkg::BytesW;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_DOMAINS);
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [BytesW-1:0] BytesMax = '1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_REG_WR,
    S_WALK,
    S_ST_RD,
    S_ST_WR,
    S_FIN_RD,
    S_OUT
  } state_e;

  state_e                       state_q;
  logic [IdW-1:0]               invalid_id_q;
  logic [CW-1:0]                count_q;
  logic [hast_pkg::ModeW-1:0]   mode_q;
  logic [IdW-1:0]               id_q;
  logic [IdW-1:0]               par_q;
  logic [hast_pkg::SizeW-1:0]   size_q;
  logic [hast_pkg::StatusW-1:0] status_q;
  hast_pkg::lookup_e            purpose_q;
  logic [IdW-1:0]               key_q;
  logic [CW-1:0]                idx_q;
  logic [CW-1:0]                level_q;
  logic [AW-1:0]                hit_q;
  logic [AW-1:0]                home_q;
  logic [IdW-1:0]               cur_q;
  logic                         zero_q;
  logic                         out_valid_q;
  logic [hast_pkg::OutDataW-1:0] out_data_q;

  // id memory and stats memory
  logic                          id_we;
  logic [hast_pkg::IdWordW-1:0]  id_rdata;
  logic                          st_we;
  logic [AW-1:0]                 st_waddr;
  logic [hast_pkg::StatsW-1:0]   st_wdata;
  logic [hast_pkg::StatsW-1:0]   st_rdata;

  assign id_we = (state_q == S_REG_WR);

  hast_ram #(.Width(hast_pkg::IdWordW), .Depth(MAX_DOMAINS)) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (id_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({par_q, id_q}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(id_rdata)
  );

  hast_ram #(.Width(hast_pkg::StatsW), .Depth(MAX_DOMAINS)) u_st_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(hit_q),
    .rdata_o(st_rdata)
  );

  // unpack the stats word read from memory
  logic [CntW-1:0]   rd_alloc, rd_free;
  logic [BytesW-1:0] rd_cur, rd_peak;
  assign rd_alloc = st_rdata[CntW-1:0];
  assign rd_free  = st_rdata[2*CntW-1:CntW];
  assign rd_cur   = st_rdata[2*CntW+BytesW-1:2*CntW];
  assign rd_peak  = st_rdata[hast_pkg::StatsW-1:2*CntW+BytesW];

  // one level of the walk: modify the stats just read
  logic [CntW-1:0]   nx_alloc, nx_free;
  logic [BytesW-1:0] nx_cur, nx_peak;
  logic [BytesW:0]   sum;
  logic              under;
  always_comb begin
    sum      = {1'b0, rd_cur} + (BytesW+1)'(size_q);
    nx_alloc = rd_alloc;
    nx_free  = rd_free;
    nx_cur   = rd_cur;
    nx_peak  = rd_peak;
    under    = 1'b0;
    if (mode_q == hast_pkg::ModeAlloc) begin
      if (rd_alloc != CntMax) nx_alloc = rd_alloc + 1'b1;
      // saturate the live bytes on overflow
      nx_cur = sum[BytesW] ? BytesMax : sum[BytesW-1:0];
      if (nx_cur > rd_peak) nx_peak = nx_cur;
    end else begin
      if (rd_free != CntMax) nx_free = rd_free + 1'b1;
      if (rd_cur < BytesW'(size_q)) begin
        nx_cur = '0;
        under  = 1'b1;
      end else begin
        nx_cur = rd_cur - BytesW'(size_q);
      end
    end
  end

  // register writes a zeroed entry, the walk writes back modified stats
  assign st_we    = (state_q == S_REG_WR) || (state_q == S_ST_WR);
  assign st_waddr = (state_q == S_REG_WR) ? count_q[AW-1:0] : hit_q;
  assign st_wdata = (state_q == S_REG_WR) ? '0 : {nx_peak, nx_cur, nx_free, nx_alloc};

  logic id_match;
  assign id_match = (id_rdata[IdW-1:0] == key_q);

  logic in_xfer, out_free;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      invalid_id_q <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= hast_pkg::StOk;
      purpose_q    <= hast_pkg::LkFin;
      idx_q        <= '0;
      level_q      <= '0;
      zero_q       <= 1'b0;
    end else begin
      if (cfg_we_i) invalid_id_q <= cfg_wdata_i;
      // result register: loaded in S_OUT, emptied by the output transfer
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            mode_q   <= s_axis_tdata[2:0];
            id_q     <= s_axis_tdata[18:3];
            par_q    <= s_axis_tdata[34:19];
            size_q   <= s_axis_tdata[66:35];
            status_q <= hast_pkg::StOk;
            zero_q   <= 1'b0;
            state_q  <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          idx_q <= '0;
          key_q <= id_q;
          if (mode_q == hast_pkg::ModeClear) begin
            count_q <= '0;
            zero_q  <= 1'b1;
            state_q <= S_OUT;
          end else if (mode_q == hast_pkg::ModeReg) begin
            if (count_q == MaxCount) begin
              status_q  <= hast_pkg::StFull;
              purpose_q <= hast_pkg::LkFin;
            end else begin
              purpose_q <= hast_pkg::LkDup;
            end
            state_q <= S_SCAN_RD;
          end else begin
            purpose_q <= hast_pkg::LkChk;
            state_q   <= S_SCAN_RD;
          end
        end

        // read id entry idx_q, or resolve a miss once the count is reached
        S_SCAN_RD: begin
          if (idx_q == count_q) begin
            case (purpose_q)
              hast_pkg::LkDup: begin
                if (par_q == invalid_id_q) begin
                  state_q <= S_REG_WR;
                end else begin
                  purpose_q <= hast_pkg::LkPar;
                  key_q     <= par_q;
                  idx_q     <= '0;
                end
              end
              hast_pkg::LkPar: begin
                status_q <= hast_pkg::StNoParent;
                zero_q   <= 1'b1;
                state_q  <= S_OUT;
              end
              hast_pkg::LkWalk: begin
                // broken chain ends the walk silently
                hit_q   <= home_q;
                state_q <= S_FIN_RD;
              end
              hast_pkg::LkChk: begin
                status_q <= hast_pkg::StUnknown;
                zero_q   <= 1'b1;
                state_q  <= S_OUT;
              end
              default: begin
                zero_q  <= 1'b1;
                state_q <= S_OUT;
              end
            endcase
          end else begin
            state_q <= S_SCAN_CMP;
          end
        end

        S_SCAN_CMP: begin
          if (id_match) begin
            hit_q <= idx_q[AW-1:0];
            case (purpose_q)
              hast_pkg::LkDup: begin
                status_q <= hast_pkg::StDup;
                state_q  <= S_FIN_RD;
              end
              hast_pkg::LkPar: begin
                state_q <= S_REG_WR;
              end
              hast_pkg::LkChk: begin
                home_q <= idx_q[AW-1:0];
                if (mode_q == hast_pkg::ModeAlloc || mode_q == hast_pkg::ModeFree) begin
                  cur_q   <= id_q;
                  level_q <= '0;
                  state_q <= S_WALK;
                end else begin
                  state_q <= S_FIN_RD;
                end
              end
              hast_pkg::LkWalk: begin
                cur_q   <= id_rdata[2*IdW-1:IdW];
                state_q <= S_ST_RD;
              end
              default: begin
                state_q <= S_FIN_RD;
              end
            endcase
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end

        S_REG_WR: begin
          hit_q   <= count_q[AW-1:0];
          count_q <= count_q + 1'b1;
          state_q <= S_FIN_RD;
        end

        // next chain level, or done at invalid_id or the level limit
        S_WALK: begin
          if (cur_q == invalid_id_q || level_q == MaxCount) begin
            hit_q   <= home_q;
            state_q <= S_FIN_RD;
          end else begin
            purpose_q <= hast_pkg::LkWalk;
            key_q     <= cur_q;
            idx_q     <= '0;
            state_q   <= S_SCAN_RD;
          end
        end

        S_ST_RD: begin
          state_q <= S_ST_WR;
        end

        S_ST_WR: begin
          if (under) status_q <= hast_pkg::StUnderflow;
          level_q <= level_q + 1'b1;
          state_q <= S_WALK;
        end

        S_FIN_RD: begin
          state_q <= S_OUT;
        end

        // stats read data stays put here: read address and memory are unchanged
        S_OUT: begin
          if (out_free) begin
            if (zero_q) begin
              out_data_q <= {5'd0, 160'd0, status_q};
            end else begin
              out_data_q <= {5'd0, rd_peak, rd_cur, rd_free, rd_alloc, status_q};
            end
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("domain count above table size");

  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ST_WR |-> level_q < MaxCount)
    else $error("chain walk past level limit");

  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_DISPATCH)
    else $error("request not dispatched");

  a_reg_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REG_WR |-> count_q < MaxCount)
    else $error("register into a full table");

endmodule

>>> hdl/hast_ram.sv
// generic single write port memory with registered read
// no dependencies
module hast_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
